[rtl/cpca_pkg.sv]
// Shared constants, state encoding and the sine table for the Clarke/Park current averager.
// Used by cpca_sine_rom and clarke_park_current_averager_top; depends on nothing else.
`timescale 1ns / 1ps

package cpca_pkg;

    // Averaging window; the average is taken with a shift, so the window is a power of two.
    localparam int WINDOW_LOG2    = 5;
    localparam int WINDOW_SAMPLES = 1 << WINDOW_LOG2;
    localparam int COUNT_W        = WINDOW_LOG2;

    // Sine table geometry.
    localparam int SINE_TABLE_DEPTH = 512;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_W           = 32 - IDX_W;
    localparam int ROM_ADDR_W       = IDX_W + 1;

    // Fixed-point constants.
    localparam logic [31:0] INV_SQRT3_Q30 = 32'h24F3_4E8B;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
    localparam int          BETA_A_SHIFT  = 30;
    localparam int          BETA_B_SHIFT  = 29;
    localparam int          PARK_SHIFT    = 31;

    // Taylor series denominators (2n)(2n+1) for terms one to ten.
    localparam logic [10:1][15:0] TAYLOR_DEN = {
        16'd420, 16'd342, 16'd272, 16'd210, 16'd156,
        16'd110, 16'd72,  16'd42,  16'd20,  16'd6
    };

    // Datapath widths.
    localparam int ACC_W   = 24;
    localparam int DQ_W    = 19;
    localparam int BETA_W  = 18;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int          ADDR_W         = 3;
    localparam logic        REG_CAL_GAIN   = 1'b0;
    localparam logic [15:0] CAL_GAIN_RESET = 16'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SIN_LO,
        ST_SIN_HI,
        ST_SIN_MUL,
        ST_SIN_ADD,
        ST_COS_MUL,
        ST_COS_ADD,
        ST_BETA_B,
        ST_BETA_SUM,
        ST_PARK_2,
        ST_PARK_3,
        ST_PARK_4,
        ST_PARK_5,
        ST_ACCUM,
        ST_OUT_D,
        ST_OUT_Q,
        ST_OUT_W
    } state_t;

    typedef logic signed [31:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    // One table entry: sin(2*pi*i/DEPTH) in Q31, from a Taylor series in Q30.
    function automatic logic signed [31:0] sine_entry(input int unsigned i);
        logic [63:0] p;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [31:0] mag;
        p    = ((64'(i) << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
        quad = p >> 30;
        r    = p & 64'h3FFF_FFFF;
        if (quad[0])
        begin
            r = (64'd1 << 30) - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DEN[n];
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        sum = sum * 2;
        if (sum < 0)
        begin
            sum = 0;
        end
        else if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
        end
        mag = sum[31:0];
        return quad[1] ? -mag : mag;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[rtl/cpca_sine_rom.sv]
// Sine lookup table with a registered read port, one entry per cycle.
// Table contents and widths come from cpca_pkg.
`timescale 1ns / 1ps

module cpca_sine_rom (
    input  logic                                 clk,
    input  logic [cpca_pkg::ROM_ADDR_W-1:0]      addr,
    output logic signed [31:0]                   data
);

    logic signed [31:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= cpca_pkg::SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

[rtl/clarke_park_current_averager_top.sv]
// Clarke/Park current averager: sequencer, shared multiplier and window accumulators.
// Depends on cpca_pkg and cpca_sine_rom.
`timescale 1ns / 1ps

// Usage
// The input channel (s_axis_*) takes one item of two signed 16-bit phase currents and a
// Q31 rotor angle. Each item is rotated into d and q and added to saturating 24-bit sums.
// After every 32nd item the output channel (m_axis_*) offers one item holding the two
// window averages times cal_gain, in milliamperes, saturated to 32 bits; the sums clear.
// An item passes through the sequencer steps ST_SIN_LO to ST_ACCUM, and a window-closing
// item also through ST_OUT_D, ST_OUT_Q and ST_OUT_W; no new item is taken until the last
// is through, limited by the single multiplier and the single ROM read port. m_axis_tvalid
// is set as the sequencer leaves ST_OUT_W. s_axis_tready is high only while the sequencer
// is idle. The result sits in an output register, so new items are taken while it waits;
// if the next window closes while the receiver still stalls, the sequencer holds at its
// last step until the register frees. The user must write cal_gain over the APB port at
// byte address 0 only while the block is idle; the block does not enforce this. Reset
// clears the sums, the sample count and the output valid, and sets cal_gain to 1.

module clarke_park_current_averager_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel. tdata: phase_a_current[15:0], phase_b_current[31:16],
    // rotor_angle[63:32].
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,
    // Output channel. tdata: d_current_ma[31:0], q_current_ma[63:32].
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [63:0]                    m_axis_tdata,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpca_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic signed [cpca_pkg::ACC_W:0] ACC_MAX =
        (cpca_pkg::ACC_W + 1)'((64'sd1 <<< (cpca_pkg::ACC_W - 1)) - 64'sd1);
    localparam logic signed [cpca_pkg::ACC_W:0] ACC_MIN = -ACC_MAX - 1;
    localparam logic signed [cpca_pkg::PROD_W-1:0] OUT_MAX =
        cpca_pkg::PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [cpca_pkg::PROD_W-1:0] OUT_MIN = -OUT_MAX - 1;
    localparam logic signed [cpca_pkg::PROD_W-1:0] ROUND_BIAS =
        cpca_pkg::PROD_W'(cpca_pkg::WINDOW_SAMPLES - 1);
    localparam logic signed [cpca_pkg::PROD_W-1:0] NO_BIAS = '0;

    cpca_pkg::state_t state_reg, state_next;

    logic [15:0]                          cal_gain_reg;
    logic signed [15:0]                   a_reg;
    logic signed [15:0]                   b_reg;
    logic [31:0]                          phase_reg;
    logic signed [31:0]                   lo_reg;
    logic signed [31:0]                   sin_reg;
    logic signed [31:0]                   cos_reg;
    logic signed [cpca_pkg::BETA_W-1:0]   beta_reg;
    logic signed [cpca_pkg::DQ_W-1:0]     d_reg;
    logic signed [cpca_pkg::DQ_W-1:0]     q_reg;
    logic signed [cpca_pkg::ACC_W-1:0]    d_acc_reg;
    logic signed [cpca_pkg::ACC_W-1:0]    q_acc_reg;
    logic [cpca_pkg::COUNT_W-1:0]         count_reg;
    logic signed [cpca_pkg::PROD_W-1:0]   prod_reg;
    logic signed [31:0]                   d_hold_reg;
    logic signed [31:0]                   d_out_reg;
    logic signed [31:0]                   q_out_reg;
    logic                                 m_valid_reg;

    logic [31:0]                          cos_phase;
    logic [cpca_pkg::IDX_W-1:0]           sin_idx;
    logic [cpca_pkg::IDX_W-1:0]           cos_idx;
    logic [cpca_pkg::ROM_ADDR_W-1:0]      rom_addr;
    logic signed [31:0]                   rom_data;
    logic signed [32:0]                   rom_diff;
    logic                                 mul_en;
    logic signed [cpca_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [cpca_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [31:0]                   interp;
    logic signed [cpca_pkg::BETA_W-1:0]   beta_part_a;
    logic signed [cpca_pkg::BETA_W-1:0]   beta_part_b;
    logic signed [cpca_pkg::DQ_W-1:0]     park_term;
    logic signed [cpca_pkg::ACC_W:0]      d_sum;
    logic signed [cpca_pkg::ACC_W:0]      q_sum;
    logic signed [cpca_pkg::PROD_W-1:0]   avg_full;
    logic signed [31:0]                   avg_sat;
    logic                                 last_sample;
    logic                                 out_free;
    logic                                 cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == cpca_pkg::REG_CAL_GAIN) ? {16'd0, cal_gain_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_gain_reg <= cpca_pkg::CAL_GAIN_RESET;
        end
        else if (cfg_write && (paddr[2] == cpca_pkg::REG_CAL_GAIN))
        begin
            cal_gain_reg <= pwdata[15:0];
        end
    end

    // Angle decode: the top bits pick the table entry, the rest interpolate.
    assign cos_phase = phase_reg + cpca_pkg::QUARTER_TURN;
    assign sin_idx   = phase_reg[31:cpca_pkg::FRAC_W];
    assign cos_idx   = cos_phase[31:cpca_pkg::FRAC_W];

    cpca_sine_rom u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign rom_diff    = {rom_data[31], rom_data} - {lo_reg[31], lo_reg};
    assign interp      = prod_reg[cpca_pkg::FRAC_W+31:cpca_pkg::FRAC_W];
    assign beta_part_a = prod_reg[cpca_pkg::BETA_A_SHIFT+cpca_pkg::BETA_W-1:cpca_pkg::BETA_A_SHIFT];
    assign beta_part_b = prod_reg[cpca_pkg::BETA_B_SHIFT+cpca_pkg::BETA_W-1:cpca_pkg::BETA_B_SHIFT];
    assign park_term   = prod_reg[cpca_pkg::PARK_SHIFT+cpca_pkg::DQ_W-1:cpca_pkg::PARK_SHIFT];

    assign d_sum = (cpca_pkg::ACC_W + 1)'(d_acc_reg) + (cpca_pkg::ACC_W + 1)'(d_reg);
    assign q_sum = (cpca_pkg::ACC_W + 1)'(q_acc_reg) + (cpca_pkg::ACC_W + 1)'(q_reg);

    // The shift floors, so negative products get a bias that makes it truncate toward zero.
    assign avg_full = (prod_reg + (prod_reg[cpca_pkg::PROD_W-1] ? ROUND_BIAS : NO_BIAS))
                      >>> cpca_pkg::WINDOW_LOG2;
    assign avg_sat  = (avg_full > OUT_MAX) ? OUT_MAX[31:0] :
                      (avg_full < OUT_MIN) ? OUT_MIN[31:0] : avg_full[31:0];

    assign last_sample = (count_reg == cpca_pkg::COUNT_W'(cpca_pkg::WINDOW_SAMPLES - 1));
    assign out_free    = !m_valid_reg || m_axis_tready;

    function automatic logic signed [cpca_pkg::ACC_W-1:0] sat_acc(
        input logic signed [cpca_pkg::ACC_W:0] v
    );
        logic signed [cpca_pkg::ACC_W-1:0] r;
        if (v > ACC_MAX)
        begin
            r = ACC_MAX[cpca_pkg::ACC_W-1:0];
        end
        else if (v < ACC_MIN)
        begin
            r = ACC_MIN[cpca_pkg::ACC_W-1:0];
        end
        else
        begin
            r = v[cpca_pkg::ACC_W-1:0];
        end
        return r;
    endfunction

    // Sequencer: next state, ROM address and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        rom_addr   = '0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            cpca_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = cpca_pkg::ST_SIN_LO;
                end
            end
            cpca_pkg::ST_SIN_LO:
            begin
                rom_addr   = {1'b0, sin_idx};
                state_next = cpca_pkg::ST_SIN_HI;
            end
            cpca_pkg::ST_SIN_HI:
            begin
                rom_addr   = {1'b0, sin_idx} + 1'b1;
                state_next = cpca_pkg::ST_SIN_MUL;
            end
            cpca_pkg::ST_SIN_MUL:
            begin
                rom_addr   = {1'b0, cos_idx};
                mul_en     = 1'b1;
                mul_a      = rom_diff[cpca_pkg::MUL_A_W-1:0];
                mul_b      = cpca_pkg::MUL_B_W'({1'b0, phase_reg[cpca_pkg::FRAC_W-1:0]});
                state_next = cpca_pkg::ST_SIN_ADD;
            end
            cpca_pkg::ST_SIN_ADD:
            begin
                rom_addr   = {1'b0, cos_idx} + 1'b1;
                state_next = cpca_pkg::ST_COS_MUL;
            end
            cpca_pkg::ST_COS_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = rom_diff[cpca_pkg::MUL_A_W-1:0];
                mul_b      = cpca_pkg::MUL_B_W'({1'b0, cos_phase[cpca_pkg::FRAC_W-1:0]});
                state_next = cpca_pkg::ST_COS_ADD;
            end
            cpca_pkg::ST_COS_ADD:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(a_reg);
                mul_b      = cpca_pkg::INV_SQRT3_Q30;
                state_next = cpca_pkg::ST_BETA_B;
            end
            cpca_pkg::ST_BETA_B:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(b_reg);
                mul_b      = cpca_pkg::INV_SQRT3_Q30;
                state_next = cpca_pkg::ST_BETA_SUM;
            end
            cpca_pkg::ST_BETA_SUM:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(a_reg);
                mul_b      = cos_reg;
                state_next = cpca_pkg::ST_PARK_2;
            end
            cpca_pkg::ST_PARK_2:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(beta_reg);
                mul_b      = sin_reg;
                state_next = cpca_pkg::ST_PARK_3;
            end
            cpca_pkg::ST_PARK_3:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(beta_reg);
                mul_b      = cos_reg;
                state_next = cpca_pkg::ST_PARK_4;
            end
            cpca_pkg::ST_PARK_4:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(a_reg);
                mul_b      = sin_reg;
                state_next = cpca_pkg::ST_PARK_5;
            end
            cpca_pkg::ST_PARK_5:
            begin
                state_next = cpca_pkg::ST_ACCUM;
            end
            cpca_pkg::ST_ACCUM:
            begin
                state_next = last_sample ? cpca_pkg::ST_OUT_D : cpca_pkg::ST_IDLE;
            end
            cpca_pkg::ST_OUT_D:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(d_acc_reg);
                mul_b      = cpca_pkg::MUL_B_W'({1'b0, cal_gain_reg});
                state_next = cpca_pkg::ST_OUT_Q;
            end
            cpca_pkg::ST_OUT_Q:
            begin
                mul_en     = 1'b1;
                mul_a      = cpca_pkg::MUL_A_W'(q_acc_reg);
                mul_b      = cpca_pkg::MUL_B_W'({1'b0, cal_gain_reg});
                state_next = cpca_pkg::ST_OUT_W;
            end
            cpca_pkg::ST_OUT_W:
            begin
                if (out_free)
                begin
                    state_next = cpca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpca_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shared multiplier with its product register.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            cpca_pkg::ST_IDLE:
            begin
                a_reg     <= s_axis_tdata[15:0];
                b_reg     <= s_axis_tdata[31:16];
                phase_reg <= s_axis_tdata[63:32];
            end
            cpca_pkg::ST_SIN_HI:
            begin
                lo_reg <= rom_data;
            end
            cpca_pkg::ST_SIN_ADD:
            begin
                sin_reg <= lo_reg + interp;
                lo_reg  <= rom_data;
            end
            cpca_pkg::ST_COS_ADD:
            begin
                cos_reg <= lo_reg + interp;
            end
            cpca_pkg::ST_BETA_B:
            begin
                beta_reg <= beta_part_a;
            end
            cpca_pkg::ST_BETA_SUM:
            begin
                beta_reg <= beta_reg + beta_part_b;
            end
            cpca_pkg::ST_PARK_2:
            begin
                d_reg <= park_term;
            end
            cpca_pkg::ST_PARK_3:
            begin
                d_reg <= d_reg + park_term;
            end
            cpca_pkg::ST_PARK_4:
            begin
                q_reg <= park_term;
            end
            cpca_pkg::ST_PARK_5:
            begin
                q_reg <= q_reg - park_term;
            end
            cpca_pkg::ST_OUT_Q:
            begin
                d_hold_reg <= avg_sat;
            end
            cpca_pkg::ST_OUT_W:
            begin
                if (out_free)
                begin
                    d_out_reg <= d_hold_reg;
                    q_out_reg <= avg_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Window state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_acc_reg   <= '0;
            q_acc_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == cpca_pkg::ST_ACCUM)
            begin
                d_acc_reg <= sat_acc(d_sum);
                q_acc_reg <= sat_acc(q_sum);
                count_reg <= last_sample ? '0 : count_reg + 1'b1;
            end
            if ((state_reg == cpca_pkg::ST_OUT_W) && out_free)
            begin
                d_acc_reg   <= '0;
                q_acc_reg   <= '0;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (state_reg == cpca_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {q_out_reg, d_out_reg};

endmodule

[dv/clarke_park_current_averager_top_test.sv]
// Self-checking testbench for the Clarke/Park current averager: a stream driver, a stream
// monitor and a bit-exact predictor of the window averages. Needs cpca_pkg and the RTL.
`timescale 1ns / 1ps

module clarke_park_current_averager_top_test;

    localparam int          ADDR_W          = cpca_pkg::ADDR_W;
    localparam logic [ADDR_W-1:0] CAL_GAIN_ADDR = ADDR_W'(4 * cpca_pkg::REG_CAL_GAIN);
    localparam int          TABLE_DEPTH     = 512;
    localparam int          WINDOW          = 32;
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 140;
    localparam int          SETTLE_CYCLES   = 24;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam longint      BETA_GAIN_Q30   = 64'sh24F3_4E8B;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
    localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
    localparam logic [31:0] TWELFTH_TURN    = 32'h1555_5555;
    localparam longint      MAX32           = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      MIN32           = 64'shFFFF_FFFF_8000_0000;
    localparam longint      SUM_MAX         = 64'sd8388607;
    localparam longint      SUM_MIN         = -64'sd8388608;

    typedef struct packed {
        logic [31:0] q;
        logic [31:0] d;
    } dq_avg_t;

    typedef enum {
        MODE_UNIFORM,
        MODE_FULL_SCALE,
        MODE_SMALL,
        MODE_TABLE_EDGE
    } stim_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // phase_a_current[15:0], phase_b_current[31:16], rotor_angle[63:32]
    logic [63:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // d_current_ma[31:0], q_current_ma[63:32]
    logic [63:0]       m_axis_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic [63:0]       sample_queue [$];
    dq_avg_t           average_queue [$];
    dq_avg_t           head_average;
    longint            sin_table [0:TABLE_DEPTH];
    longint            cal_gain_model;
    longint            d_sum;
    longint            q_sum;
    int                window_fill;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    bit                idle_enable = 1'b0;
    int                send_gap;
    int                stall_left;

    clarke_park_current_averager_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Sine of x radians (Q30, first quadrant) as Q31, from x and ten further Taylor terms.
    function automatic longint taylor_sine_q31(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        return clamp(acc * 2, 0, MAX32);
    endfunction

    function automatic void build_sin_table();
        logic [31:0] p;
        logic [63:0] r;
        longint      s;
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            p = 32'((64'(i) << 32) / TABLE_DEPTH);
            r = 64'(p[29:0]);
            if (p[30])
            begin
                r = (64'd1 << 30) - r;
            end
            s = taylor_sine_q31((r * HALF_PI_Q30) >> 30);
            sin_table[i] = p[31] ? -s : s;
        end
    endfunction

    // The angle is an unsigned fraction of a turn; interpolate between table entries.
    function automatic longint angle_sine(logic [31:0] phase);
        logic [63:0] pos;
        int unsigned idx;
        longint      frac;
        longint      lo;
        longint      hi;
        pos  = 64'(phase) * 64'(TABLE_DEPTH);
        idx  = pos[63:32];
        frac = longint'(pos[31:0]);
        lo   = sin_table[idx];
        hi   = sin_table[idx + 1];
        return lo + (((hi - lo) * frac) >>> 32);
    endfunction

    // Rotate one accepted item into d and q, add it to the window, and queue the
    // window average when the window closes.
    function automatic void absorb_sample(logic [63:0] word);
        longint      a;
        longint      b;
        longint      beta;
        longint      s;
        longint      c;
        longint      d;
        longint      q;
        logic [31:0] phase;
        dq_avg_t     avg;
        a     = longint'($signed(word[15:0]));
        b     = longint'($signed(word[31:16]));
        phase = word[63:32];
        beta  = clamp(((a * BETA_GAIN_Q30) >>> 30) + ((b * BETA_GAIN_Q30) >>> 29), MIN32, MAX32);
        s     = angle_sine(phase);
        c     = angle_sine(32'(phase + QUARTER_TURN));
        d     = clamp(((a * c) >>> 31) + ((beta * s) >>> 31), MIN32, MAX32);
        q     = clamp(((beta * c) >>> 31) - ((a * s) >>> 31), MIN32, MAX32);
        d_sum = clamp(d_sum + d, SUM_MIN, SUM_MAX);
        q_sum = clamp(q_sum + q, SUM_MIN, SUM_MAX);
        window_fill++;
        if (window_fill == WINDOW)
        begin
            avg.d = 32'(clamp(d_sum * cal_gain_model / WINDOW, MIN32, MAX32));
            avg.q = 32'(clamp(q_sum * cal_gain_model / WINDOW, MIN32, MAX32));
            average_queue.push_back(avg);
            d_sum       = 0;
            q_sum       = 0;
            window_fill = 0;
        end
    endfunction

    function automatic logic [63:0] pack_sample(logic [15:0] a, logic [15:0] b,
                                                logic [31:0] angle);
        return {angle, b, a};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAL_GAIN_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Driver: the prediction is taken at the edge that accepts an item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_sample(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_enable && $urandom_range(0, 3) == 0)
                begin
                    send_gap      <= $urandom_range(0, 8);
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    s_axis_tdata  <= sample_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (average_queue.size() == 0)
                begin
                    report_mismatch($sformatf("item %h with no average pending", m_axis_tdata));
                end
                else
                begin
                    head_average = average_queue.pop_front();
                    if (m_axis_tdata[31:0] !== head_average.d)
                    begin
                        report_mismatch($sformatf("d_current_ma %h, predicted %h",
                                                  m_axis_tdata[31:0], head_average.d));
                    end
                    if (m_axis_tdata[63:32] !== head_average.q)
                    begin
                        report_mismatch($sformatf("q_current_ma %h, predicted %h",
                                                  m_axis_tdata[63:32], head_average.q));
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                stall_left    <= $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] rd;
        logic [63:0] word;
        logic [15:0] fs_a;
        logic [15:0] fs_b;
        logic [31:0] fs_angle;
        int          gain_plan [PHASES-1];
        int          queued_total;
        stim_mode_t  mode;

        build_sin_table();
        cal_gain_model = 1;
        d_sum          = 0;
        q_sum          = 0;
        window_fill    = 0;
        queued_total   = 0;
        mode           = MODE_UNIFORM;
        fs_a           = '0;
        fs_b           = '0;
        fs_angle       = '0;
        gain_plan = '{65535, 0, 32768, $urandom_range(0, 65535), 1, 65535,
                      $urandom_range(0, 65535), 2, $urandom_range(0, 65535)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // The first phase runs on the reset value of the gain.
            if (ph > 0)
            begin
                apb_access(1'b1, 32'(gain_plan[ph - 1]), rd);
                cal_gain_model = gain_plan[ph - 1];
            end
            apb_access(1'b0, '0, rd);
            if (longint'(rd[15:0]) != cal_gain_model)
            begin
                report_mismatch($sformatf("cal_gain reads %h, written %0d", rd, cal_gain_model));
            end

            @(negedge clk);
            idle_enable = (ph < PHASES - 2);
            if (ph == 0)
            begin
                sample_queue.push_back(pack_sample(16'h0000, 16'h0000, 32'h0000_0000));
                sample_queue.push_back(pack_sample(16'h7FFF, 16'h0000, 32'h0000_0000));
                sample_queue.push_back(pack_sample(16'h8000, 16'h0000, 32'h0000_0000));
                sample_queue.push_back(pack_sample(16'h0000, 16'h7FFF, 32'h4000_0000));
                sample_queue.push_back(pack_sample(16'h0000, 16'h8000, 32'h4000_0000));
                sample_queue.push_back(pack_sample(16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF));
                // Minus and plus half a turn are the same angle.
                sample_queue.push_back(pack_sample(16'h8000, 16'h8000, 32'h8000_0000));
                sample_queue.push_back(pack_sample(16'h8000, 16'h7FFF, 32'hFFFF_FFFF));
                sample_queue.push_back(pack_sample(16'h7FFF, 16'h8000, 32'h0000_0001));
                sample_queue.push_back(pack_sample(16'h7FFF, 16'h7FFF, 32'hC000_0000));
                sample_queue.push_back(pack_sample(16'h8000, 16'h8000, 32'hAAAA_AAAB));
                sample_queue.push_back(pack_sample(16'h8000, 16'h8000, 32'h2AAA_AAAB));
                sample_queue.push_back(pack_sample(16'h0001, 16'hFFFF, 32'h0080_0000));
                sample_queue.push_back(pack_sample(16'hFFFF, 16'h0001, 32'h007F_FFFF));
                sample_queue.push_back(pack_sample(16'h7FFF, 16'h8000, 32'hFF80_0000));
                sample_queue.push_back(pack_sample(16'h3039, 16'hA460, 32'h3FFF_FFFF));
                sample_queue.push_back(pack_sample(16'h8000, 16'h7FFF, 32'h4000_0001));
                sample_queue.push_back(pack_sample(16'h7FFF, 16'h0000, 32'hBFFF_FFFF));
                sample_queue.push_back(pack_sample(16'h0000, 16'h0000, 32'h8000_0001));
                sample_queue.push_back(pack_sample(16'hFFFF, 16'hFFFF, 32'h1234_5678));
                queued_total = 20;
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Each block of a window's length shares one flavor of stimulus.
                if (queued_total % WINDOW == 0)
                begin
                    mode     = stim_mode_t'($urandom_range(0, 3));
                    fs_a     = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    fs_b     = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    fs_angle = TWELFTH_TURN * 32'($urandom_range(0, 11));
                end
                case (mode)
                    MODE_FULL_SCALE:
                    begin
                        word = {fs_angle + 32'($urandom_range(0, 1023)), fs_b, fs_a};
                    end
                    MODE_SMALL:
                    begin
                        word = {$urandom(), 16'($urandom_range(0, 64) - 32),
                                16'($urandom_range(0, 64) - 32)};
                    end
                    MODE_TABLE_EDGE:
                    begin
                        word = {(32'($urandom_range(0, 511)) << 23) +
                                32'($urandom_range(0, 2)) - 32'd1, $urandom()};
                    end
                    default:
                    begin
                        word = {$urandom(), $urandom()};
                    end
                endcase
                sample_queue.push_back(word);
                queued_total++;
            end

            while (sample_queue.size() != 0 || s_axis_tvalid)
            begin
                @(negedge clk);
            end
            while (average_queue.size() != 0)
            begin
                @(negedge clk);
            end
            // An item that closes no window may still be in flight.
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (mismatch_count == 0 && average_queue.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
